// File: rtl/pbaf_pkg.sv
// ----------------------------------------------------------------------------
// pbaf_pkg
// Types, field widths, register indexes and problem bit positions shared by
// the price bar anomaly flagger.
// ----------------------------------------------------------------------------
`default_nettype none

package pbaf_pkg;

  localparam int PRICE_W    = 32;
  localparam int RATIO_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int MASK_W     = 20;
  localparam int PROD_W     = PRICE_W + RATIO_W;
  localparam int IN_DATA_W  = 3 * PRICE_W;
  localparam int OUT_DATA_W = ((MASK_W + 2 + 7) / 8) * 8;
  localparam int IDX_W      = 3;

  typedef logic signed [PRICE_W-1:0] price_t;
  typedef logic signed [PRICE_W:0]   wide_price_t;

  typedef struct packed {
    price_t cl;
    price_t lo;
    price_t hi;
  } bar_t;

  typedef struct packed {
    logic               en_range;
    logic               en_jump;
    logic               en_rep;
    logic               en_sim;
    logic               en_ratio;
    logic [RATIO_W-1:0] sim_ratio;
    logic [RATIO_W-1:0] min_ratio;
  } cfg_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CHECK_RANGE      = 3'd0,
    REG_CHECK_NEXT_JUMP  = 3'd1,
    REG_CHECK_REPEATS    = 3'd2,
    REG_CHECK_SIMILARITY = 3'd3,
    REG_CHECK_RATIO      = 3'd4,
    REG_SIM_RATIO        = 3'd5,
    REG_MIN_RATIO        = 3'd6
  } reg_idx_t;

  localparam logic [RATIO_W-1:0] SIM_RATIO_RST = 17'd6554;
  localparam logic [RATIO_W-1:0] MIN_RATIO_RST = 17'd32768;

  // problem bit positions
  localparam int B_HI_NONPOS   = 0;
  localparam int B_LO_NONPOS   = 1;
  localparam int B_CL_NONPOS   = 2;
  localparam int B_HI_BELOW_LO = 3;
  localparam int B_CL_ABOVE_HI = 4;
  localparam int B_CL_BELOW_LO = 5;
  localparam int B_CL_MISSING  = 6;
  localparam int B_HI_MISSING  = 7;
  localparam int B_LO_MISSING  = 8;
  localparam int B_CL_JUMP     = 9;
  localparam int B_HI_JUMP     = 10;
  localparam int B_LO_JUMP     = 11;
  localparam int B_CL_REPEAT   = 12;
  localparam int B_HI_REPEAT   = 13;
  localparam int B_LO_REPEAT   = 14;
  localparam int B_CL_AT_HI    = 15;
  localparam int B_CL_AT_LO    = 16;
  localparam int B_BAR_SIMILAR = 17;
  localparam int B_CL_SIMILAR  = 18;
  localparam int B_RATIO_LOW   = 19;

  // bits that belong to the high/low verdict, the rest belong to the close
  localparam logic [MASK_W-1:0] HILO_MASK =
    (MASK_W'(1) << B_HI_NONPOS)   | (MASK_W'(1) << B_LO_NONPOS)   |
    (MASK_W'(1) << B_HI_BELOW_LO) | (MASK_W'(1) << B_HI_MISSING)  |
    (MASK_W'(1) << B_LO_MISSING)  | (MASK_W'(1) << B_HI_JUMP)     |
    (MASK_W'(1) << B_LO_JUMP)     | (MASK_W'(1) << B_HI_REPEAT)   |
    (MASK_W'(1) << B_LO_REPEAT)   | (MASK_W'(1) << B_BAR_SIMILAR) |
    (MASK_W'(1) << B_RATIO_LOW);

  localparam price_t PRICE_MISSING = {1'b0, {(PRICE_W-1){1'b1}}};

  typedef enum logic [1:0] {
    PH_FIRST  = 2'b01,
    PH_SECOND = 2'b10
  } phase_t;

  function automatic wide_price_t sx(input price_t x);
    return {x[PRICE_W-1], x};
  endfunction

  function automatic logic [PRICE_W:0] mag(input wide_price_t x);
    return x[PRICE_W] ? (PRICE_W+1)'(-x) : (PRICE_W+1)'(x);
  endfunction

endpackage

`default_nettype wire

// File: rtl/pbaf_cfg.sv
// ----------------------------------------------------------------------------
// pbaf_cfg
// Configuration register file: check enables and the two Q1.16 ratios.
// ----------------------------------------------------------------------------
`default_nettype none

module pbaf_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pbaf_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pbaf_pkg::RATIO_W-1:0] cfg_data,
  output pbaf_pkg::cfg_t                    cfg
);
  import pbaf_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.en_range  <= 1'b1;
      cfg.en_jump   <= 1'b1;
      cfg.en_rep    <= 1'b1;
      cfg.en_sim    <= 1'b1;
      cfg.en_ratio  <= 1'b1;
      cfg.sim_ratio <= SIM_RATIO_RST;
      cfg.min_ratio <= MIN_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHECK_RANGE:      cfg.en_range  <= cfg_data[0];
        REG_CHECK_NEXT_JUMP:  cfg.en_jump   <= cfg_data[0];
        REG_CHECK_REPEATS:    cfg.en_rep    <= cfg_data[0];
        REG_CHECK_SIMILARITY: cfg.en_sim    <= cfg_data[0];
        REG_CHECK_RATIO:      cfg.en_ratio  <= cfg_data[0];
        REG_SIM_RATIO:        cfg.sim_ratio <= cfg_data;
        REG_MIN_RATIO:        cfg.min_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/pbaf_judge.sv
// ----------------------------------------------------------------------------
// pbaf_judge
// Checks one bar against its next bar and the two bars before it and
// builds the problem mask.
// ----------------------------------------------------------------------------
`default_nettype none

module pbaf_judge (
  input  wire pbaf_pkg::bar_t              b,
  input  wire pbaf_pkg::bar_t              nx,
  input  wire logic                        nx_valid,
  input  wire pbaf_pkg::bar_t              p1,
  input  wire pbaf_pkg::bar_t              p2,
  input  wire logic [1:0]                  hist,
  input  wire pbaf_pkg::cfg_t              cfg,
  output logic [pbaf_pkg::MASK_W-1:0]      mask
);
  import pbaf_pkg::*;

  wide_price_t        d1, d2, dif;
  logic               dif_pos;
  logic [PROD_W-1:0]  limit;
  logic               hc, lc, chc, clc;
  logic [PROD_W-1:0]  ratio_rhs, ratio_lhs;
  logic               hi_pos, hist_full;

  assign d1      = sx(b.hi) - sx(b.lo);
  assign d2      = sx(p1.hi) - sx(p1.lo);
  assign dif     = (d1 > d2) ? d1 : d2;
  assign dif_pos = !dif[PRICE_W] && (dif != '0);
  assign limit   = PROD_W'(dif[PRICE_W-1:0]) * PROD_W'(cfg.sim_ratio);

  // slide within limit: |a - b| * 2^16 < range * ratio
  assign hc  = {mag(sx(b.hi) - sx(p1.hi)), {FRAC_W{1'b0}}} < limit;
  assign lc  = {mag(sx(b.lo) - sx(p1.lo)), {FRAC_W{1'b0}}} < limit;
  assign chc = {mag(sx(b.cl) - sx(p1.hi)), {FRAC_W{1'b0}}} < limit;
  assign clc = {mag(sx(b.cl) - sx(p1.lo)), {FRAC_W{1'b0}}} < limit;

  assign hi_pos    = !b.hi[PRICE_W-1] && (b.hi != '0);
  assign ratio_rhs = PROD_W'(cfg.min_ratio) * PROD_W'(b.hi[PRICE_W-1:0]);
  assign ratio_lhs = {1'b0, b.lo, {FRAC_W{1'b0}}};
  assign hist_full = hist[1];

  always_comb begin
    mask = '0;
    if (cfg.en_range) begin
      mask[B_HI_NONPOS]   = b.hi[PRICE_W-1] || (b.hi == '0);
      mask[B_LO_NONPOS]   = b.lo[PRICE_W-1] || (b.lo == '0);
      mask[B_CL_NONPOS]   = b.cl[PRICE_W-1] || (b.cl == '0);
      mask[B_HI_BELOW_LO] = b.hi < b.lo;
      mask[B_CL_ABOVE_HI] = b.cl > b.hi;
      mask[B_CL_BELOW_LO] = b.cl < b.lo;
      mask[B_CL_MISSING]  = b.cl == PRICE_MISSING;
      mask[B_HI_MISSING]  = b.hi == PRICE_MISSING;
      mask[B_LO_MISSING]  = b.lo == PRICE_MISSING;
    end
    if (cfg.en_jump && nx_valid) begin
      mask[B_CL_JUMP] = sx(nx.cl) > wide_price_t'({b.cl, 1'b0});
      mask[B_HI_JUMP] = sx(nx.hi) > wide_price_t'({b.hi, 1'b0});
      mask[B_LO_JUMP] = sx(nx.lo) > wide_price_t'({b.lo, 1'b0});
    end
    if (hist_full && cfg.en_rep) begin
      mask[B_CL_REPEAT] = (b.cl == p1.cl) && (b.cl == p2.cl);
      mask[B_HI_REPEAT] = (b.hi == p1.hi) && (b.hi == p2.hi);
      mask[B_LO_REPEAT] = (b.lo == p1.lo) && (b.lo == p2.lo);
      mask[B_CL_AT_HI]  = (b.cl == b.hi) && (b.cl == p1.hi);
      mask[B_CL_AT_LO]  = (b.cl == b.lo) && (b.cl == p1.lo);
    end
    if (hist_full && cfg.en_sim && dif_pos) begin
      mask[B_BAR_SIMILAR] = hc && lc;
      mask[B_CL_SIMILAR]  = (hc && chc) || (lc && clc);
    end
    if (cfg.en_ratio && hi_pos) begin
      mask[B_RATIO_LOW] = b.lo[PRICE_W-1] || (ratio_lhs < ratio_rhs);
    end
  end

endmodule

`default_nettype wire

// File: rtl/price_bar_anomaly_flagger.sv
// ----------------------------------------------------------------------------
// price_bar_anomaly_flagger
// Flags each price bar of a series: holds one bar until the next arrives,
// keeps two earlier bars, and returns ok flags and a problem mask per bar.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   bar high, low, close; tlast ends series
//  m_*      out        m_tvalid/m_tready   range_ok, close_ok, problem mask
//  cfg_*    in         cfg_valid/cfg_ready register index and write data
//
//  one word per cycle in unless a result waits on a stalled output; a bar that
//  releases the held bar and ends its series holds the input while the held bar
//  is judged, set by the single shared check unit and the single result register.
//  reset clears the history, the held bar and all valid flags.
//  a stalled output holds the check unit when it has a result to write and,
//  through it, the input register.
`default_nettype none

module price_bar_anomaly_flagger (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // bar_high, bar_low, bar_close
  input  wire logic [pbaf_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // range_ok, close_ok, problem_mask, zero pad
  output logic [pbaf_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pbaf_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [pbaf_pkg::RATIO_W-1:0]    cfg_data
);
  import pbaf_pkg::*;

  cfg_t              cfg;
  logic              in_v;
  bar_t              in_bar;
  logic              in_end;
  bar_t              older, prior, pending;
  logic [1:0]        bbp;
  logic              pend_v;
  phase_t            phase;
  logic              out_v;
  logic [MASK_W-1:0] out_mask;
  logic              out_last;

  logic              use_pend, has_res, can_go, in_done;
  bar_t              jb;
  logic [MASK_W-1:0] mask;

  pbaf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign use_pend = (phase == PH_FIRST) && pend_v;
  assign has_res  = use_pend || in_end;
  assign can_go   = in_v && (!has_res || !out_v || m_tready);
  assign in_done  = can_go && !(use_pend && in_end);
  assign s_tready = !in_v || in_done;
  assign jb       = use_pend ? pending : in_bar;

  pbaf_judge u_judge (
    .b        (jb),
    .nx       (in_bar),
    .nx_valid (use_pend),
    .p1       (prior),
    .p2       (older),
    .hist     (bbp),
    .cfg      (cfg),
    .mask     (mask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_bar.hi <= s_tdata[PRICE_W-1:0];
      in_bar.lo <= s_tdata[2*PRICE_W-1:PRICE_W];
      in_bar.cl <= s_tdata[3*PRICE_W-1:2*PRICE_W];
      in_end    <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      bbp    <= 2'd0;
      phase  <= PH_FIRST;
    end else if (can_go) begin
      if (use_pend) begin
        older  <= prior;
        prior  <= pending;
        bbp    <= bbp[1] ? bbp : bbp + 2'd1;
        pend_v <= 1'b0;
        if (in_end) begin
          phase <= PH_SECOND;
        end else begin
          pending <= in_bar;
          pend_v  <= 1'b1;
        end
      end else if (in_end) begin
        bbp   <= 2'd0;
        phase <= PH_FIRST;
      end else begin
        pending <= in_bar;
        pend_v  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (can_go && has_res) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
    if (can_go && has_res) begin
      out_mask <= mask;
      out_last <= !use_pend;
    end
  end

  assign m_tvalid = out_v;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_DATA_W'({out_mask,
                                 !(|(out_mask & ~HILO_MASK)),
                                 !(|(out_mask & HILO_MASK))});

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the price bar anomaly flagger. A directed table of
// bars covers the field extremes, the missing-price marker, every problem bit
// and short or flat history. It is followed by random series: runs of nearby
// bars with repeats, closes at the extremes, doublings and noise, under several
// check settings. Every accepted bar goes through a local flagging model, and
// each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb;

  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int HOLD_PHASE      = 4;
  localparam int QUIET_PHASE     = 3;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE          = 8;
  localparam int LIMIT           = 1000000;
  localparam logic [pbaf_pkg::IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    pbaf_pkg::price_t hi;
    pbaf_pkg::price_t lo;
    pbaf_pkg::price_t cl;
  } quote_t;

  typedef struct {
    quote_t                      q;
    bit                          last;
    bit                          typed;
    bit                          t_range_ok;
    bit                          t_close_ok;
    logic [pbaf_pkg::MASK_W-1:0] t_mask;
  } stim_t;

  typedef struct {
    bit                          range_ok;
    bit                          close_ok;
    logic [pbaf_pkg::MASK_W-1:0] mask;
    bit                          last;
  } verdict_t;

  logic                               clk = 1'b1;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [pbaf_pkg::IN_DATA_W-1:0]     s_tdata = '0;
  logic                               s_tlast = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [pbaf_pkg::OUT_DATA_W-1:0]    m_tdata;
  logic                               m_tlast;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [pbaf_pkg::IDX_W-1:0]         cfg_index = '0;
  logic [pbaf_pkg::RATIO_W-1:0]       cfg_data = '0;

  price_bar_anomaly_flagger u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // flagging model state
  bit                            chk_range = 1'b1;
  bit                            chk_jump = 1'b1;
  bit                            chk_rep = 1'b1;
  bit                            chk_sim = 1'b1;
  bit                            chk_ratio = 1'b1;
  logic [pbaf_pkg::RATIO_W-1:0]  slide_frac = pbaf_pkg::SIM_RATIO_RST;
  logic [pbaf_pkg::RATIO_W-1:0]  min_frac = pbaf_pkg::MIN_RATIO_RST;
  quote_t                        older_q = '{0, 0, 0};
  quote_t                        prior_q = '{0, 0, 0};
  quote_t                        held_q = '{0, 0, 0};
  int                            held_depth = 0;
  bit                            held_valid = 1'b0;

  verdict_t                      verdict_q[$];
  verdict_t                      fresh[$];

  bit                            tx_idle = 1'b1;
  bit                            rx_idle = 1'b1;
  bit                            hold_req = 1'b0;
  longint                        drift_base = 1000;
  int                            fail_cnt = 0;
  int                            bars_sent = 0;
  int                            series_cnt = 0;
  int                            results_seen = 0;
  int                            settings_cnt = 1;
  int                            cycle_cnt = 0;
  logic [pbaf_pkg::MASK_W-1:0]   seen_bits = '0;

  function automatic bit within_slide(longint a, longint b, logic [63:0] lim);
    logic [63:0] d;
    d = (a > b) ? a - b : b - a;
    return (d * 64'd65536) < lim;
  endfunction

  function automatic logic [pbaf_pkg::MASK_W-1:0] flag_bar(quote_t b, bit has_next,
                                                           quote_t nx, int depth);
    logic [pbaf_pkg::MASK_W-1:0] m;
    longint h, l, c, nh, nl, nc, ph, pl, pc, oh, ol, oc, d1, d2, dif, miss, mf;
    logic [63:0] ud, lim;
    bit hc, lc, cc;
    m = '0;
    h = longint'(b.hi);  l = longint'(b.lo);  c = longint'(b.cl);
    nh = longint'(nx.hi); nl = longint'(nx.lo); nc = longint'(nx.cl);
    ph = longint'(prior_q.hi); pl = longint'(prior_q.lo); pc = longint'(prior_q.cl);
    oh = longint'(older_q.hi); ol = longint'(older_q.lo); oc = longint'(older_q.cl);
    miss = longint'(pbaf_pkg::PRICE_MISSING);
    if (chk_range) begin
      if (h <= 0) m[pbaf_pkg::B_HI_NONPOS] = 1'b1;
      if (l <= 0) m[pbaf_pkg::B_LO_NONPOS] = 1'b1;
      if (c <= 0) m[pbaf_pkg::B_CL_NONPOS] = 1'b1;
      if (h < l) m[pbaf_pkg::B_HI_BELOW_LO] = 1'b1;
      if (c > h) m[pbaf_pkg::B_CL_ABOVE_HI] = 1'b1;
      if (c < l) m[pbaf_pkg::B_CL_BELOW_LO] = 1'b1;
      if (c == miss) m[pbaf_pkg::B_CL_MISSING] = 1'b1;
      if (h == miss) m[pbaf_pkg::B_HI_MISSING] = 1'b1;
      if (l == miss) m[pbaf_pkg::B_LO_MISSING] = 1'b1;
    end
    if (chk_jump && has_next) begin
      if (nc > c * 2) m[pbaf_pkg::B_CL_JUMP] = 1'b1;
      if (nh > h * 2) m[pbaf_pkg::B_HI_JUMP] = 1'b1;
      if (nl > l * 2) m[pbaf_pkg::B_LO_JUMP] = 1'b1;
    end
    if (depth >= 2) begin
      if (chk_rep) begin
        if (c == pc && c == oc) m[pbaf_pkg::B_CL_REPEAT] = 1'b1;
        if (h == ph && h == oh) m[pbaf_pkg::B_HI_REPEAT] = 1'b1;
        if (l == pl && l == ol) m[pbaf_pkg::B_LO_REPEAT] = 1'b1;
        if (c == h && c == ph) m[pbaf_pkg::B_CL_AT_HI] = 1'b1;
        if (c == l && c == pl) m[pbaf_pkg::B_CL_AT_LO] = 1'b1;
      end
      if (chk_sim) begin
        d1 = h - l;
        d2 = ph - pl;
        dif = (d1 > d2) ? d1 : d2;
        if (dif > 0) begin
          ud = dif;
          lim = ud * 64'(slide_frac);
          hc = 1'b0; lc = 1'b0; cc = 1'b0;
          if (within_slide(h, ph, lim)) begin
            hc = 1'b1;
            if (within_slide(c, ph, lim)) cc = 1'b1;
          end
          if (within_slide(l, pl, lim)) begin
            lc = 1'b1;
            if (within_slide(c, pl, lim)) cc = 1'b1;
          end
          if (hc && lc) m[pbaf_pkg::B_BAR_SIMILAR] = 1'b1;
          if (cc) m[pbaf_pkg::B_CL_SIMILAR] = 1'b1;
        end
      end
    end
    if (chk_ratio && h > 0) begin
      mf = longint'(min_frac);
      if (l < 0 || l * 65536 < mf * h) m[pbaf_pkg::B_RATIO_LOW] = 1'b1;
    end
    return m;
  endfunction

  function automatic verdict_t make_verdict(logic [pbaf_pkg::MASK_W-1:0] m, bit last);
    verdict_t v;
    v.range_ok = ((m & pbaf_pkg::HILO_MASK) == '0);
    v.close_ok = ((m & ~pbaf_pkg::HILO_MASK) == '0);
    v.mask     = m;
    v.last     = last;
    return v;
  endfunction

  // one accepted bar: release the held bar, then judge this one if it ends a series
  task automatic advance_series(quote_t q, bit last);
    fresh.delete();
    if (held_valid) begin
      fresh.push_back(make_verdict(flag_bar(held_q, 1'b1, q, held_depth), 1'b0));
      older_q = prior_q;
      prior_q = held_q;
      if (held_depth < 2) held_depth++;
      held_valid = 1'b0;
    end
    if (last) begin
      fresh.push_back(make_verdict(flag_bar(q, 1'b0, q, held_depth), 1'b1));
      held_depth = 0;
    end else begin
      held_q = q;
      held_valid = 1'b1;
    end
  endtask

  task automatic apply_reg(logic [pbaf_pkg::IDX_W-1:0] idx, logic [pbaf_pkg::RATIO_W-1:0] val);
    case (idx)
      pbaf_pkg::REG_CHECK_RANGE:      chk_range = val[0];
      pbaf_pkg::REG_CHECK_NEXT_JUMP:  chk_jump = val[0];
      pbaf_pkg::REG_CHECK_REPEATS:    chk_rep = val[0];
      pbaf_pkg::REG_CHECK_SIMILARITY: chk_sim = val[0];
      pbaf_pkg::REG_CHECK_RATIO:      chk_ratio = val[0];
      pbaf_pkg::REG_SIM_RATIO:        slide_frac = val;
      pbaf_pkg::REG_MIN_RATIO:        min_frac = val;
      default: ;
    endcase
  endtask

  // called at a falling edge with the block idle
  task automatic load_settings(bit [4:0] en, logic [pbaf_pkg::RATIO_W-1:0] sim,
                               logic [pbaf_pkg::RATIO_W-1:0] minr);
    logic [pbaf_pkg::IDX_W-1:0]   idx [8];
    logic [pbaf_pkg::RATIO_W-1:0] val [8];
    idx[0] = pbaf_pkg::REG_CHECK_RANGE;      val[0] = {16'd0, en[0]};
    idx[1] = pbaf_pkg::REG_CHECK_NEXT_JUMP;  val[1] = {16'd0, en[1]};
    idx[2] = pbaf_pkg::REG_CHECK_REPEATS;    val[2] = {16'd0, en[2]};
    idx[3] = pbaf_pkg::REG_CHECK_SIMILARITY; val[3] = {16'd0, en[3]};
    idx[4] = pbaf_pkg::REG_CHECK_RATIO;      val[4] = {16'd0, en[4]};
    idx[5] = pbaf_pkg::REG_SIM_RATIO;        val[5] = sim;
    idx[6] = pbaf_pkg::REG_MIN_RATIO;        val[6] = minr;
    // unused index, must leave every register alone
    idx[7] = REG_SPARE;                      val[7] = 17'($urandom_range(0, 65536));
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  function automatic int tx_gap();
    int r;
    if (!tx_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic int rx_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_bar(stim_t w);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w.q.cl, w.q.lo, w.q.hi};
    s_tlast  <= w.last;
    do @(posedge clk); while (!s_tready);
    advance_series(w.q, w.last);
    if (w.typed) begin
      fresh[fresh.size()-1].range_ok = w.t_range_ok;
      fresh[fresh.size()-1].close_ok = w.t_close_ok;
      fresh[fresh.size()-1].mask     = w.t_mask;
    end
    foreach (fresh[i]) verdict_q.push_back(fresh[i]);
    bars_sent++;
    if (w.last) series_cnt++;
    @(negedge clk);
  endtask

  task automatic settle();
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic stim_t row(pbaf_pkg::price_t hi, pbaf_pkg::price_t lo,
                                pbaf_pkg::price_t cl, bit last, bit typed, bit rok,
                                bit cok, logic [pbaf_pkg::MASK_W-1:0] m);
    stim_t s;
    s.q.hi = hi; s.q.lo = lo; s.q.cl = cl;
    s.last = last;
    s.typed = typed;
    s.t_range_ok = rok;
    s.t_close_ok = cok;
    s.t_mask = m;
    return s;
  endfunction

  function automatic longint pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return longint'($urandom_range(2, 5000));
    if (r < 8) return longint'($urandom_range(5000, 32'h0100_0000));
    if (r < 9) return longint'($urandom_range(32'h0100_0000, 32'h1FFF_FFFF));
    return -longint'($urandom_range(0, 1000));
  endfunction

  function automatic quote_t next_bar(quote_t prev);
    quote_t b;
    int r;
    longint span, step, lo_v, hi_v;
    b = prev;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      b = prev;
    end else if (r < 14) begin
      b.hi = $urandom;
      b.lo = $urandom;
      b.cl = $urandom;
    end else if (r < 17) begin
      case ($urandom_range(0, 2))
        0: b.hi = pbaf_pkg::PRICE_MISSING;
        1: b.lo = pbaf_pkg::PRICE_MISSING;
        default: b.cl = pbaf_pkg::PRICE_MISSING;
      endcase
    end else if (r < 21) begin
      // doubling, right at the boundary or one past it
      b.hi = pbaf_pkg::price_t'(longint'(prev.hi) * 2 + $urandom_range(0, 1));
      b.lo = pbaf_pkg::price_t'(longint'(prev.lo) * 2 + $urandom_range(0, 1));
      b.cl = pbaf_pkg::price_t'(longint'(prev.cl) * 2 + $urandom_range(0, 1));
    end else begin
      span = (drift_base < 0 ? -drift_base : drift_base) / $urandom_range(4, 60) + 1;
      step = longint'($urandom_range(0, 32'(span))) - span / 2;
      drift_base = drift_base + step / 4;
      lo_v = drift_base - longint'($urandom_range(0, 32'(span)));
      hi_v = lo_v + longint'($urandom_range(0, 32'(span)));
      b.hi = pbaf_pkg::price_t'(hi_v);
      b.lo = pbaf_pkg::price_t'(lo_v);
      case ($urandom_range(0, 9))
        0: b.cl = pbaf_pkg::price_t'(hi_v);
        1: b.cl = pbaf_pkg::price_t'(lo_v);
        default: b.cl = pbaf_pkg::price_t'(lo_v + longint'($urandom_range(0, 32'(hi_v - lo_v))));
      endcase
    end
    return b;
  endfunction

  // output side: random stalls, plus one long hold on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && rx_idle && $urandom_range(0, 99) < 25) begin
        stall = rx_stall();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    logic [pbaf_pkg::MASK_W-1:0] got_mask;
    if (!rst && m_tvalid && m_tready) begin
      got_mask = m_tdata[2 +: pbaf_pkg::MASK_W];
      results_seen++;
      seen_bits = seen_bits | got_mask;
      if (verdict_q.size() == 0) begin
        $error("result word with no prediction waiting: tdata %h", m_tdata);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.range_ok) begin
          $error("range_ok: expected %0b, got %0b", want.range_ok, m_tdata[0]);
          fail_cnt++;
        end
        if (m_tdata[1] !== want.close_ok) begin
          $error("close_ok: expected %0b, got %0b", want.close_ok, m_tdata[1]);
          fail_cnt++;
        end
        if (got_mask !== want.mask) begin
          $error("problem_mask: expected %05h, got %05h", want.mask, got_mask);
          fail_cnt++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_series: expected %0b, got %0b", want.last, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    stim_t            dir_tab[$];
    quote_t           prev, cur;
    int               sent, len;
    bit               lst;
    bit [4:0]         en;
    logic [pbaf_pkg::RATIO_W-1:0] sim, minr;
    pbaf_pkg::price_t pmax, pmin;

    pmax = pbaf_pkg::PRICE_MISSING;
    pmin = 32'sh8000_0000;
    // single-bar series with verdicts read straight off the rules
    dir_tab.push_back(row(100, 50, 75, 1, 1, 1, 1, 20'h00000));
    dir_tab.push_back(row(0, 0, 0, 1, 1, 0, 0, 20'h00007));
    dir_tab.push_back(row(pmax, pmax, pmax, 1, 1, 0, 0, 20'h001C0));
    dir_tab.push_back(row(pmin, pmin, pmin, 1, 1, 0, 0, 20'h00007));
    dir_tab.push_back(row(10, 20, 30, 1, 1, 0, 0, 20'h00018));
    dir_tab.push_back(row(100, 10, 5, 1, 1, 0, 0, 20'h80020));
    dir_tab.push_back(row(-5, 3, 2, 1, 1, 0, 0, 20'h00039));
    dir_tab.push_back(row(100, -5, 50, 1, 1, 0, 1, 20'h80002));
    dir_tab.push_back(row(32'sh5555_5555, 32'sh2AAA_AAAA, 32'sh4000_0000, 1, 0, 0, 0, 0));
    // repeats, doubling, close at high then at low
    dir_tab.push_back(row(100, 60, 80, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(100, 60, 80, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(100, 60, 80, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(300, 130, 250, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(300, 130, 300, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(310, 130, 130, 1, 0, 0, 0, 0));
    // short history
    dir_tab.push_back(row(100, 60, 80, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(100, 60, 80, 1, 0, 0, 0, 0));
    // flat bars, zero range
    dir_tab.push_back(row(50, 50, 50, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(50, 50, 50, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(50, 50, 50, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(50, 50, 50, 1, 0, 0, 0, 0));
    // extremes back to back
    dir_tab.push_back(row(32'sh7FFF_FFFE, 32'sh4000_0000, 32'sh5000_0000, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(pmin, pmax, pmin, 1, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_bar(dir_tab[i]);
    s_tvalid <= 1'b0;
    settle();

    prev = '{100, 60, 80};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin en = 5'b00000; sim = 17'd0; minr = 17'd0; end
        1: begin en = 5'b11111; sim = 17'd65536; minr = 17'd65536; end
        2: begin en = 5'b11111; sim = 17'd0; minr = 17'd0; end
        default: begin
          for (int k = 0; k < 5; k++) en[k] = ($urandom_range(0, 3) != 0);
          sim = ($urandom_range(0, 4) == 0) ? 17'd65536 : 17'($urandom_range(0, 16384));
          minr = 17'($urandom_range(0, 65536));
        end
      endcase
      load_settings(en, sim, minr);
      tx_idle = (ph != QUIET_PHASE && ph != HOLD_PHASE);
      rx_idle = (ph != QUIET_PHASE);
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
        drift_base = pick_base();
        for (int k = 0; k < len && sent < ITEMS_PER_PHASE; k++) begin
          cur = next_bar(prev);
          lst = (k == len - 1) || (sent == ITEMS_PER_PHASE - 1);
          send_bar(row(cur.hi, cur.lo, cur.cl, lst, 0, 0, 0, 0));
          prev = cur;
          sent++;
        end
        if ($urandom_range(0, 39) == 0) begin
          s_tvalid <= 1'b0;
          while (verdict_q.size() != 0) @(negedge clk);
        end
      end
      s_tvalid <= 1'b0;
      settle();
    end

    repeat (SETTLE) @(posedge clk);
    $display("%0d bars in %0d series under %0d check settings, %0d result words checked",
             bars_sent, series_cnt, settings_cnt, results_seen);
    $display("problem bits raised: %05h; long output hold and full drain pauses included",
             seen_bits);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
